### hdl/cvq_pkg.sv
// Shared constants and types for the codebook vector quantizer.
package cvq_pkg;

    // Default sizes
    localparam int DEF_MAX_CODEWORDS  = 64;
    localparam int DEF_MAX_DIMS       = 128;
    localparam int DEF_SET_SIZE_LIMIT = 4096;

    // Field widths
    localparam int CW_IDX_W   = 6;
    localparam int DIM_IDX_W  = 7;
    localparam int CENT_W     = 16;
    localparam int DESC_W     = 8;
    localparam int COUNT_W    = 12;
    localparam int VALUE_W    = 17;
    localparam int CFG_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;

    // Element difference and its square
    localparam int DIFF_W = CENT_W + 1;
    localparam int SQ_W   = 2 * CENT_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CODEWORDS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS      = 1'd1;

    // Register reset values
    localparam logic [6:0] RST_CODEWORDS = 7'd64;
    localparam logic [7:0] RST_DIMS      = 8'd128;

    // Kind codes
    localparam logic KIND_CODEBOOK   = 1'b0;
    localparam logic KIND_DESCRIPTOR = 1'b1;

    // Tag traveling with each element pair through the distance unit
    typedef struct packed {
        logic valid;
        logic last;
    } t_mac_tag;

endpackage

### hdl/codebook_vector_quantizer.sv
// Top level: codebook vector quantizer with histogram output.
//
// Codebook elements (kind 0) and descriptor elements (kind 1) are taken only
// while the block is idle. After a descriptor's last element the block is busy:
// one shared squared-difference multiplier walks every element of every
// codeword in use, fed by one codebook RAM read per cycle, then the winning bin
// is read and incremented. On the last descriptor of a set every bin in use is
// emitted; each bin waits for the one-bit-a-step divider and then for the
// consumer. After reset and after each emitted histogram the block sweeps all
// MAX_CODEWORDS bins clearing their counts and accepts no item meanwhile.
// Configuration writes are always taken and must only be issued while the
// block is idle.
module codebook_vector_quantizer #(
    parameter int MAX_CODEWORDS  = cvq_pkg::DEF_MAX_CODEWORDS,
    parameter int MAX_DIMS       = cvq_pkg::DEF_MAX_DIMS,
    parameter int SET_SIZE_LIMIT = cvq_pkg::DEF_SET_SIZE_LIMIT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [cvq_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cvq_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // input items
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_kind,
    input  logic [cvq_pkg::CW_IDX_W-1:0]       i_codeword_index,
    input  logic [cvq_pkg::DIM_IDX_W-1:0]      i_dim_index,
    input  logic [cvq_pkg::CENT_W-1:0]         i_centroid_value,
    input  logic [cvq_pkg::DESC_W-1:0]         i_descriptor_value,
    input  logic                               i_last_element,
    input  logic                               i_last_descriptor,
    // results
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [cvq_pkg::CW_IDX_W-1:0]       o_bin_index,
    output logic [cvq_pkg::COUNT_W-1:0]        o_bin_count,
    output logic [cvq_pkg::VALUE_W-1:0]        o_bin_value,
    output logic                               o_last_bin
);
    import cvq_pkg::*;

    localparam int BW     = (MAX_CODEWORDS > 1) ? $clog2(MAX_CODEWORDS) : 1;
    localparam int DW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NW     = $clog2(MAX_CODEWORDS + 1);
    localparam int KW     = $clog2(MAX_DIMS + 1);
    localparam int AW     = $clog2(MAX_CODEWORDS * MAX_DIMS);
    localparam int CB     = $clog2(SET_SIZE_LIMIT);
    localparam int DIST_W = SQ_W + KW;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_SEARCH, S_BRD, S_BWR, S_ERD, S_EDIV, S_EWAIT, S_EOUT
    } t_state;

    t_state            r_state;
    logic [6:0]        r_cw_reg;
    logic [7:0]        r_dim_reg;
    logic [NW-1:0]     ncw;
    logic [KW-1:0]     nd;
    logic [BW-1:0]     r_clr;
    logic              r_last_set;
    // search
    logic              r_issue;
    logic [DW-1:0]     r_k;
    logic [BW-1:0]     r_jiss;
    logic [AW-1:0]     r_base;
    logic [BW-1:0]     r_jcmp;
    t_mac_tag          r_rd_tag;
    logic              mac_done;
    logic [DIST_W-1:0] mac_dist;
    logic [DIST_W-1:0] r_best;
    logic [BW-1:0]     r_win;
    logic              k_last;
    // histogram
    logic [CB-1:0]     r_largest;
    logic [BW-1:0]     r_i;
    logic [CB-1:0]     r_cnt;
    logic [CB-1:0]     new_cnt;
    // memories
    logic              cb_we;
    logic [AW-1:0]     cb_waddr;
    logic [CENT_W-1:0] cb_rdata;
    logic              ds_we;
    logic [DESC_W-1:0] ds_rdata;
    logic              bn_we;
    logic [BW-1:0]     bn_addr;
    logic [CB-1:0]     bn_wdata;
    logic [CB-1:0]     bn_rdata;
    // divider
    logic              div_start;
    logic              div_done;
    logic [VALUE_W-1:0] div_quot;
    logic [31:0]       cnt_ext;
    logic              in_acc;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;

    // Clamp the registers to the built sizes; zero codewords counts as one
    always_comb begin
        if (r_cw_reg == 7'd0) begin
            ncw = NW'(1);
        end else if (32'(r_cw_reg) > MAX_CODEWORDS) begin
            ncw = NW'(MAX_CODEWORDS);
        end else begin
            ncw = NW'(r_cw_reg);
        end
        if (32'(r_dim_reg) > MAX_DIMS) begin
            nd = KW'(MAX_DIMS);
        end else begin
            nd = KW'(r_dim_reg);
        end
    end

    // Store loads into the codebook and descriptor buffers
    assign cb_we = in_acc && (i_kind == KIND_CODEBOOK)
                   && (32'(i_codeword_index) < MAX_CODEWORDS)
                   && (32'(i_dim_index) < MAX_DIMS);
    assign cb_waddr = AW'(32'(i_codeword_index) * MAX_DIMS + 32'(i_dim_index));
    assign ds_we = in_acc && (i_kind == KIND_DESCRIPTOR)
                   && (32'(i_dim_index) < MAX_DIMS);

    cvq_ram #(.WIDTH(CENT_W), .DEPTH(MAX_CODEWORDS * MAX_DIMS)) u_codebook (
        .i_clk   (i_clk),
        .i_we    (cb_we),
        .i_waddr (cb_waddr),
        .i_wdata (i_centroid_value),
        .i_raddr (r_base + AW'(r_k)),
        .o_rdata (cb_rdata)
    );

    cvq_ram #(.WIDTH(DESC_W), .DEPTH(MAX_DIMS)) u_descbuf (
        .i_clk   (i_clk),
        .i_we    (ds_we),
        .i_waddr (DW'(32'(i_dim_index))),
        .i_wdata (i_descriptor_value),
        .i_raddr (r_k),
        .o_rdata (ds_rdata)
    );

    cvq_mac #(.DIST_W(DIST_W)) u_mac (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tag        (r_rd_tag),
        .i_centroid   (cb_rdata),
        .i_descriptor (ds_rdata),
        .o_done       (mac_done),
        .o_dist       (mac_dist)
    );

    // Bin count memory: clear sweep, increment, emit read
    always_comb begin
        case (r_state)
            S_CLR:         bn_addr = r_clr;
            S_BRD, S_BWR:  bn_addr = r_win;
            default:       bn_addr = r_i;
        endcase
    end
    assign new_cnt  = (32'(bn_rdata) < SET_SIZE_LIMIT - 1) ? bn_rdata + CB'(1) : bn_rdata;
    assign bn_we    = (r_state == S_CLR) || (r_state == S_BWR);
    assign bn_wdata = (r_state == S_CLR) ? '0 : new_cnt;

    cvq_ram #(.WIDTH(CB), .DEPTH(MAX_CODEWORDS)) u_bins (
        .i_clk   (i_clk),
        .i_we    (bn_we),
        .i_waddr (bn_addr),
        .i_wdata (bn_wdata),
        .i_raddr (bn_addr),
        .o_rdata (bn_rdata)
    );

    assign div_start = (r_state == S_EDIV);

    // Start the divide straight from the bin read data
    cvq_div #(.CB(CB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   ({bn_rdata, 16'd0} + (CB + 16)'(r_largest >> 1)),
        .i_den   (r_largest),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign k_last  = (32'(r_k) + 1 == 32'(nd));
    assign cnt_ext = 32'(r_cnt);

    // Sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr       <= '0;
            r_cw_reg    <= RST_CODEWORDS;
            r_dim_reg   <= RST_DIMS;
            r_issue     <= 1'b0;
            r_rd_tag    <= '0;
            r_largest   <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_CODEWORDS) begin
                    r_cw_reg <= i_cfg_data[6:0];
                end else if (i_cfg_index == REG_DIMS) begin
                    r_dim_reg <= i_cfg_data;
                end
            end
            r_rd_tag <= '{valid: r_issue, last: k_last};
            case (r_state)
                S_CLR: begin
                    r_largest <= '0;
                    r_clr     <= r_clr + BW'(1);
                    if (32'(r_clr) == MAX_CODEWORDS - 1) begin
                        r_clr   <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc && (i_kind == KIND_DESCRIPTOR) && i_last_element) begin
                        r_last_set <= i_last_descriptor;
                        r_k        <= '0;
                        r_jiss     <= '0;
                        r_jcmp     <= '0;
                        r_base     <= '0;
                        r_win      <= '0;
                        if (nd == '0) begin
                            r_state <= S_BRD;
                        end else begin
                            r_issue <= 1'b1;
                            r_state <= S_SEARCH;
                        end
                    end
                end
                S_SEARCH: begin
                    // advance the read address over dims, then codewords
                    if (r_issue) begin
                        if (k_last) begin
                            r_k    <= '0;
                            r_jiss <= r_jiss + BW'(1);
                            r_base <= r_base + AW'(MAX_DIMS);
                            if (32'(r_jiss) + 1 == 32'(ncw)) begin
                                r_issue <= 1'b0;
                            end
                        end else begin
                            r_k <= r_k + DW'(1);
                        end
                    end
                    // keep the nearest codeword, lowest index on ties
                    if (mac_done) begin
                        if (r_jcmp == '0 || mac_dist < r_best) begin
                            r_best <= mac_dist;
                            r_win  <= r_jcmp;
                        end
                        r_jcmp <= r_jcmp + BW'(1);
                        if (32'(r_jcmp) + 1 == 32'(ncw)) begin
                            r_state <= S_BRD;
                        end
                    end
                end
                S_BRD: begin
                    r_state <= S_BWR;
                end
                S_BWR: begin
                    if (new_cnt > r_largest) begin
                        r_largest <= new_cnt;
                    end
                    r_i     <= '0;
                    r_state <= r_last_set ? S_ERD : S_IDLE;
                end
                S_ERD: begin
                    r_state <= S_EDIV;
                end
                S_EDIV: begin
                    r_cnt   <= bn_rdata;
                    r_state <= S_EWAIT;
                end
                S_EWAIT: begin
                    if (div_done) begin
                        o_bin_index <= CW_IDX_W'(32'(r_i));
                        o_bin_count <= cnt_ext[COUNT_W-1:0];
                        o_bin_value <= (r_largest == '0) ? '0 : div_quot;
                        o_last_bin  <= (32'(r_i) + 1 == 32'(ncw));
                        o_out_valid <= 1'b1;
                        r_state     <= S_EOUT;
                    end
                end
                S_EOUT: begin
                    if (i_out_ready) begin
                        o_out_valid <= 1'b0;
                        r_i         <= r_i + BW'(1);
                        r_state     <= o_last_bin ? S_CLR : S_ERD;
                    end
                end
                default: r_state <= S_CLR;
            endcase
        end
    end

    // Checks
    a_no_accept_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("input taken while a bin is pending");
    a_value_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_bin_value <= VALUE_W'(65536)))
        else $error("bin value above 1.0");
    a_last_bin_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_last_bin) |-> (32'(o_bin_index) + 1 == 32'(ncw)))
        else $error("last bin flag on wrong bin");
    a_largest_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_largest) < SET_SIZE_LIMIT) else $error("largest count out of range");
endmodule

### hdl/cvq_ram.sv
// Generic simple dual-port RAM with registered read.
module cvq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hdl/cvq_mac.sv
// Shared squared-difference multiply and distance accumulator.
module cvq_mac #(
    parameter int DIST_W = 40
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cvq_pkg::t_mac_tag         i_tag,
    input  logic [cvq_pkg::CENT_W-1:0] i_centroid,
    input  logic [cvq_pkg::DESC_W-1:0] i_descriptor,
    output logic                      o_done,
    output logic [DIST_W-1:0]         o_dist
);
    import cvq_pkg::*;

    logic signed [DIFF_W-1:0]   diff;
    logic signed [2*DIFF_W-1:0] sq;
    logic [SQ_W-1:0]            r_prod;
    t_mac_tag                   r_ptag;
    logic [DIST_W-1:0]          r_acc;
    logic [DIST_W-1:0]          sum;

    // Centroid minus descriptor scaled to Q8.8
    assign diff = $signed({1'b0, i_centroid}) - $signed({1'b0, i_descriptor, 8'd0});
    assign sq   = diff * diff;
    assign sum  = r_acc + DIST_W'(r_prod);

    // Register the square, then accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptag <= '0;
            r_acc  <= '0;
            o_done <= 1'b0;
        end else begin
            r_ptag <= i_tag;
            o_done <= r_ptag.valid && r_ptag.last;
            if (r_ptag.valid) begin
                r_acc <= r_ptag.last ? '0 : sum;
            end
        end
        r_prod <= sq[SQ_W-1:0];
        if (r_ptag.valid && r_ptag.last) begin
            o_dist <= sum;
        end
    end
endmodule

### hdl/cvq_div.sv
// Bit-serial restoring divider for the normalized bin value.
module cvq_div #(
    parameter int CB = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [CB+15:0]                    i_num,
    input  logic [CB-1:0]                     i_den,
    output logic                              o_done,
    output logic [cvq_pkg::VALUE_W-1:0]       o_quot
);
    import cvq_pkg::*;

    logic [CB-1:0]      r_rem;
    logic [VALUE_W-1:0] r_lo;
    logic [CB-1:0]      r_den;
    logic [4:0]         r_cnt;
    logic               r_busy;
    logic [CB:0]        trial;
    logic               fits;

    // Shift in the next numerator bit and test against the divisor
    assign trial = {r_rem, r_lo[VALUE_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'(VALUE_W - 1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_rem <= CB'(i_num >> VALUE_W);
            r_lo  <= i_num[VALUE_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= fits ? CB'(trial - {1'b0, r_den}) : trial[CB-1:0];
            r_lo  <= {r_lo[VALUE_W-2:0], fits};
        end
    end

    assign o_quot = r_lo;
endmodule

### verif/cvq_checker.sv
// Checker for the codebook vector quantizer: predicts each histogram and compares results.
module cvq_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [cvq_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cvq_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  logic                           i_kind,
    input  logic [cvq_pkg::CW_IDX_W-1:0]   i_codeword_index,
    input  logic [cvq_pkg::DIM_IDX_W-1:0]  i_dim_index,
    input  logic [cvq_pkg::CENT_W-1:0]     i_centroid_value,
    input  logic [cvq_pkg::DESC_W-1:0]     i_descriptor_value,
    input  logic                           i_last_element,
    input  logic                           i_last_descriptor,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  logic [cvq_pkg::CW_IDX_W-1:0]   i_bin_index,
    input  logic [cvq_pkg::COUNT_W-1:0]    i_bin_count,
    input  logic [cvq_pkg::VALUE_W-1:0]    i_bin_value,
    input  logic                           i_last_bin,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_bins_seen,
    output int                             o_sets_seen
);
    timeunit 1ns;
    timeprecision 1ps;
    import cvq_pkg::*;

    localparam int NCW  = DEF_MAX_CODEWORDS;
    localparam int NDIM = DEF_MAX_DIMS;
    localparam int CAP  = DEF_SET_SIZE_LIMIT - 1;

    typedef struct packed {
        logic [CW_IDX_W-1:0] idx;
        logic [COUNT_W-1:0]  cnt;
        logic [VALUE_W-1:0]  val;
        logic                last;
    } t_bin_result;

    logic [CENT_W-1:0]  centroid_mem [NCW*NDIM];
    logic [DESC_W-1:0]  desc_mem [NDIM];
    logic [COUNT_W-1:0] hist [NCW];
    logic [COUNT_W-1:0] peak_count;
    logic [6:0]         reg_codewords;
    logic [7:0]         reg_dims;
    t_bin_result        expected_bins[$];

    initial begin
        for (int i = 0; i < NCW*NDIM; i++) centroid_mem[i] = '0;
        for (int i = 0; i < NDIM; i++) desc_mem[i] = '0;
        for (int i = 0; i < NCW; i++) hist[i] = '0;
        peak_count    = '0;
        reg_codewords = RST_CODEWORDS;
        reg_dims      = RST_DIMS;
        o_fail_count  = 0;
        o_pending     = 0;
        o_bins_seen   = 0;
        o_sets_seen   = 0;
    end

    function automatic int active_codewords();
        int n;
        n = reg_codewords;
        if (n == 0) n = 1;
        if (n > NCW) n = NCW;
        return n;
    endfunction

    // Search the codebook for the nearest centroid, lowest index on ties
    function automatic int find_nearest();
        longint unsigned best, cw_dist;
        longint          diff;
        int              nd, win;
        nd = (reg_dims > NDIM) ? NDIM : int'(reg_dims);
        best = 0;
        win = 0;
        for (int j = 0; j < active_codewords(); j++) begin
            cw_dist = 0;
            for (int k = 0; k < nd; k++) begin
                diff = longint'(centroid_mem[j*NDIM+k]) - (longint'(desc_mem[k]) << 8);
                cw_dist += longint'(diff * diff);
            end
            if (j == 0 || cw_dist < best) begin
                best = cw_dist;
                win = j;
            end
        end
        return win;
    endfunction

    // Apply one accepted input transaction to the predicted state
    task automatic absorb_item();
        int          win;
        t_bin_result r;
        longint unsigned num;
        if (i_kind == KIND_CODEBOOK) begin
            centroid_mem[int'(i_codeword_index)*NDIM + int'(i_dim_index)] = i_centroid_value;
        end else begin
            desc_mem[i_dim_index] = i_descriptor_value;
            if (i_last_element) begin
                win = find_nearest();
                if (hist[win] < CAP) hist[win] = hist[win] + 1'b1;
                if (hist[win] > peak_count) peak_count = hist[win];
                if (i_last_descriptor) begin
                    for (int i = 0; i < active_codewords(); i++) begin
                        r.idx = i[CW_IDX_W-1:0];
                        r.cnt = hist[i];
                        num = 0;
                        if (peak_count != 0)
                            num = (longint'(hist[i]) * 65536 + longint'(peak_count / 2))
                                  / longint'(peak_count);
                        r.val  = num[VALUE_W-1:0];
                        r.last = (i + 1 == active_codewords());
                        expected_bins = {expected_bins, r};
                    end
                    for (int i = 0; i < NCW; i++) hist[i] = '0;
                    peak_count = '0;
                end
            end
        end
    endtask

    // Compare one result transaction with the oldest expectation
    task automatic compare_bin();
        t_bin_result want, got;
        got = '{i_bin_index, i_bin_count, i_bin_value, i_last_bin};
        o_bins_seen++;
        if (i_last_bin) o_sets_seen++;
        if (expected_bins.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10)
                $display("%0t: unexpected bin idx=%0d cnt=%0d val=%0d last=%0b",
                         $realtime, got.idx, got.cnt, got.val, got.last);
        end else begin
            want = expected_bins.pop_front();
            if (got != want) begin
                o_fail_count++;
                if (o_fail_count <= 10)
                    $display("%0t: bin mismatch exp idx=%0d cnt=%0d val=%0d last=%0b, got idx=%0d cnt=%0d val=%0d last=%0b",
                             $realtime, want.idx, want.cnt, want.val, want.last,
                             got.idx, got.cnt, got.val, got.last);
            end
        end
    endtask

    // Watch all three channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_CODEWORDS) reg_codewords = i_cfg_data[6:0];
                else if (i_cfg_index == REG_DIMS) reg_dims = i_cfg_data;
            end
            if (i_in_valid && i_in_ready) absorb_item();
            if (i_out_valid && i_out_ready) compare_bin();
            o_pending = expected_bins.size();
        end
    end

endmodule

### verif/tb_codebook_vector_quantizer.sv
// Testbench top for the codebook vector quantizer: stimulus, idling phases and verdict.
module tb_codebook_vector_quantizer;
    timeunit 1ns;
    timeprecision 1ps;
    import cvq_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic                  i_kind;
    logic [CW_IDX_W-1:0]   i_codeword_index;
    logic [DIM_IDX_W-1:0]  i_dim_index;
    logic [CENT_W-1:0]     i_centroid_value;
    logic [DESC_W-1:0]     i_descriptor_value;
    logic                  i_last_element;
    logic                  i_last_descriptor;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [CW_IDX_W-1:0]   o_bin_index;
    logic [COUNT_W-1:0]    o_bin_count;
    logic [VALUE_W-1:0]    o_bin_value;
    logic                  o_last_bin;

    int fail_count, pending, bins_seen, sets_seen;
    int idle_pct, stall_pct;
    int items_sent, phase_no;
    int cur_cw, cur_dims;

    codebook_vector_quantizer i_dut (.*);

    cvq_checker i_checker (
        .i_clk, .i_rst_n,
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_kind, .i_codeword_index, .i_dim_index,
        .i_centroid_value, .i_descriptor_value, .i_last_element, .i_last_descriptor,
        .i_out_valid(o_out_valid), .i_out_ready, .i_bin_index(o_bin_index),
        .i_bin_count(o_bin_count), .i_bin_value(o_bin_value), .i_last_bin(o_last_bin),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_bins_seen(bins_seen), .o_sets_seen(sets_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result channel at the rate of the current phase
    always @(posedge i_clk) i_out_ready <= ($urandom_range(99) >= stall_pct);

    initial begin
        #20_000_000;
        $display("timeout with %0d bins still expected", pending);
        $display("FAILURE");
        $finish;
    end

    // Send one input transaction after a random idle gap; valid stays high
    task automatic send_item(logic kind, logic [5:0] cw, logic [6:0] dim,
                             logic [15:0] cval, logic [7:0] dval, logic le, logic ld);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_kind             <= kind;
        i_codeword_index   <= cw;
        i_dim_index        <= dim;
        i_centroid_value   <= cval;
        i_descriptor_value <= dval;
        i_last_element     <= le;
        i_last_descriptor  <= ld;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain outstanding bins, then let the search and clear sweep finish
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (cur_cw * cur_dims + 200) @(posedge i_clk);
    endtask

    // Reconfigure while idle and pick the idling mode of the next phase
    task automatic start_phase(logic [7:0] cw_data, logic [7:0] dims_data);
        int m;
        settle();
        write_reg(REG_CODEWORDS, cw_data);
        write_reg(REG_DIMS, dims_data);
        m = cw_data[6:0];
        cur_cw   = (m == 0) ? 1 : ((m > 64) ? 64 : m);
        cur_dims = (dims_data > 128) ? 128 : int'(dims_data);
        case (phase_no % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 83; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 83; end
            default: begin idle_pct = 38; stall_pct = 38; end
        endcase
        phase_no++;
    endtask

    // Load every centroid element in use; some codewords copy codeword 0 for ties
    task automatic load_codebook();
        logic [15:0] row0 [128];
        logic        dup;
        logic [15:0] v;
        for (int j = 0; j < cur_cw; j++) begin
            dup = (j > 0) && ($urandom_range(3) == 0);
            for (int k = 0; k < cur_dims; k++) begin
                v = dup ? row0[k] : 16'($urandom);
                if (j == 0) row0[k] = v;
                send_item(KIND_CODEBOOK, j[5:0], k[6:0], v, 8'($urandom),
                          1'($urandom), 1'($urandom));
            end
        end
    endtask

    // Stray transactions: loads anywhere, or descriptor elements that end nothing
    task automatic send_noise();
        send_item(1'($urandom), 6'($urandom), 7'($urandom), 16'($urandom),
                  8'($urandom), 1'b0, 1'($urandom));
    endtask

    // One descriptor; may end early once the buffer has been filled in this phase
    task automatic send_descriptor(logic ld, logic may_break);
        int stop;
        stop = cur_dims - 1;
        if (cur_dims == 0) begin
            send_item(KIND_DESCRIPTOR, 6'($urandom), 7'($urandom), 16'($urandom),
                      8'($urandom), 1'b1, ld);
            return;
        end
        if (may_break && cur_dims > 1 && $urandom_range(9) == 0)
            stop = $urandom_range(cur_dims - 2);
        for (int k = 0; k <= stop; k++) begin
            if ($urandom_range(19) == 0) send_noise();
            send_item(KIND_DESCRIPTOR, 6'($urandom), k[6:0], 16'($urandom),
                      8'($urandom), k == stop, (k == stop) && ld);
        end
    endtask

    task automatic run_sets(int nsets);
        int nd;
        for (int s = 0; s < nsets; s++) begin
            nd = $urandom_range(1, 4);
            for (int d = 0; d < nd; d++)
                send_descriptor(d == nd - 1, (s > 0) || (d > 0));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= REG_CODEWORDS;
        i_cfg_data  <= '0;
        i_in_valid  <= 1'b0;
        i_kind      <= KIND_CODEBOOK;
        i_codeword_index   <= '0;
        i_dim_index        <= '0;
        i_centroid_value   <= '0;
        i_descriptor_value <= '0;
        i_last_element     <= 1'b0;
        i_last_descriptor  <= 1'b0;
        i_out_ready        <= 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        phase_no = 0;
        cur_cw = 1;
        cur_dims = 1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (100) @(posedge i_clk);

        // Directed: extreme centroids, a tie, flags on loads, stray end-of-set mark
        start_phase(8'd3, 8'd4);
        for (int k = 0; k < 4; k++) begin
            send_item(KIND_CODEBOOK, 6'd0, k[6:0], 16'h0000, 8'hFF, 1'b1, 1'b1);
            send_item(KIND_CODEBOOK, 6'd1, k[6:0], 16'hFFFF, 8'h00, 1'b1, 1'b1);
            send_item(KIND_CODEBOOK, 6'd2, k[6:0], 16'h0000, 8'h00, 1'b0, 1'b0);
        end
        for (int k = 0; k < 4; k++)
            send_item(KIND_DESCRIPTOR, 6'd0, k[6:0], 16'd0, 8'd0, k == 3, 1'b0);
        send_item(KIND_DESCRIPTOR, 6'd0, 7'd0, 16'd0, 8'd255, 1'b0, 1'b1);
        for (int k = 0; k < 4; k++)
            send_item(KIND_DESCRIPTOR, 6'd63, k[6:0], 16'd0, 8'd255, k == 3, k == 3);
        send_item(KIND_DESCRIPTOR, 6'd0, 7'd127, 16'd0, 8'd128, 1'b1, 1'b1);

        // Zero codewords acts as one
        start_phase(8'd0, 8'd5);
        load_codebook();
        run_sets(2);

        // Zero dims: every distance is zero, so bin 0 takes each descriptor
        start_phase(8'd2, 8'd0);
        for (int d = 0; d < 20; d++) send_descriptor(1'b0, 1'b0);
        send_descriptor(1'b1, 1'b0);

        // Full descriptor length, oversized dims register
        start_phase(8'd1, 8'd255);
        load_codebook();
        send_descriptor(1'b1, 1'b0);

        // Full codebook width, oversized codewords register
        start_phase(8'd255, 8'd1);
        load_codebook();
        run_sets(2);

        // Random small configurations
        while (items_sent < 460) begin
            start_phase(8'($urandom_range(1, 4)), 8'($urandom_range(1, 8)));
            load_codebook();
            run_sets($urandom_range(2, 5));
        end

        settle();
        $display("ran %0d phases, %0d input transactions, %0d bins in %0d histograms",
                 phase_no, items_sent, bins_seen, sets_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches, %0d bins never arrived", fail_count, pending);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
